// File: sv/lisfw_pkg.sv
// Shared types, constants and the microprogram ROM of the LIS prefix-maximum tree core.
package lisfw_pkg;

   localparam int LEN_W         = 11;                 // length fields and tree entries
   localparam int VALUE_W       = 11;                 // input value field
   localparam int EPOCH_W       = 4;                  // sequence tag kept with each entry
   localparam int MAX_VALUE_DEF = 1024;
   localparam int PC_W          = 3;

   localparam logic [LEN_W-1:0] LEN_MAX = '1;

   typedef logic [PC_W-1:0] pc_type;

   // Program addresses
   localparam pc_type P_FETCH  = 3'd0;
   localparam pc_type P_NEWSEQ = 3'd1;
   localparam pc_type P_QINIT  = 3'd2;
   localparam pc_type P_QWALK  = 3'd3;
   localparam pc_type P_UINIT  = 3'd4;
   localparam pc_type P_UWALK  = 3'd5;
   localparam pc_type P_EMIT   = 3'd6;
   localparam pc_type P_SWEEP  = 3'd7;

   // Datapath action of one step
   typedef enum logic [2:0] {
      OP_FETCH,
      OP_NEWSEQ,
      OP_QINIT,
      OP_QSTEP,
      OP_UINIT,
      OP_USTEP,
      OP_EMIT,
      OP_SWEEP
   } op_type;

   // Sequencing of one step
   typedef enum logic [2:0] {
      J_WAIT_IN,     // hold until a transaction is taken, then next
      J_WRAP,        // to target when the epoch wraps on a new sequence, else next
      J_REJ,         // to target when the value is out of range, else next
      J_LOOP_NZ,     // hold while the query index is nonzero, else next
      J_LOOP_RANGE,  // hold while the update index is inside the tree, else next
      J_WAIT_OUT,    // hold until the result register is free, then target
      J_SWEEP        // hold until the last entry, then target (fetch while booting)
   } jump_type;

   typedef struct packed {
      op_type   op;
      jump_type jump;
      pc_type   target;
   } ucode_type;

   function automatic ucode_type ucode_rom(input pc_type pc);
      ucode_type w;
      unique case (pc)
         P_FETCH:  w = '{op: OP_FETCH,  jump: J_WAIT_IN,    target: P_FETCH};
         P_NEWSEQ: w = '{op: OP_NEWSEQ, jump: J_WRAP,       target: P_SWEEP};
         P_QINIT:  w = '{op: OP_QINIT,  jump: J_REJ,        target: P_EMIT};
         P_QWALK:  w = '{op: OP_QSTEP,  jump: J_LOOP_NZ,    target: P_QWALK};
         P_UINIT:  w = '{op: OP_UINIT,  jump: J_WAIT_IN,    target: P_UWALK};
         P_UWALK:  w = '{op: OP_USTEP,  jump: J_LOOP_RANGE, target: P_UWALK};
         P_EMIT:   w = '{op: OP_EMIT,   jump: J_WAIT_OUT,   target: P_FETCH};
         P_SWEEP:  w = '{op: OP_SWEEP,  jump: J_SWEEP,      target: P_QINIT};
         default:  w = '{op: OP_FETCH,  jump: J_WAIT_IN,    target: P_FETCH};
      endcase
      return w;
   endfunction

endpackage

// File: sv/lis_length_prefix_max_tree_core.sv
// Top level: streaming LIS length core over a Fenwick tree of prefix maxima.
// Usage
//   req channel: one transaction per sequence value. tdata[10:0] is the value,
//   tuser marks the first value of a new sequence (tree and best length are
//   cleared before that value is applied). Values of 0 or above MAX_VALUE are
//   rejected and leave the tree alone.
//   rsp channel: one transaction per request, in order: ending length, best
//   length so far and a rejected flag.
// Operation
//   One value at a time through an 8-step microprogram: fetch, new-sequence check,
//   query init, query walk down the prefix entries, update init, update walk up
//   the tree and emit; the sweep step clears the RAM. Rejects skip both walks.
// Reset
//   Synchronous, active high. After reset the tree RAM is swept, one entry a
//   cycle, over all MAX_VALUE entries while req_tready stays low. A new sequence
//   only bumps a 4-bit epoch tag; every 16th one repeats that sweep.
// Stall
//   The result sits in an output register; the core fetches and processes the
//   next value while it waits and only holds when a second result is ready.
module lis_length_prefix_max_tree_core #(
   parameter int MAX_VALUE = lisfw_pkg::MAX_VALUE_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [10:0] value, [15:11] zero
   input  logic        req_tuser,   // [0] first_of_sequence
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [10:0] ending_length, [21:11] best_length, [23:22] zero
   output logic        rsp_tuser    // [0] rejected
);

   import lisfw_pkg::*;

   localparam int ADDR_W = $clog2(MAX_VALUE);
   localparam int IDX_W  = $clog2(MAX_VALUE) + 2;   // holds up to 2*MAX_VALUE
   localparam int DATA_W = EPOCH_W + LEN_W;

   localparam logic [IDX_W-1:0]  IDX_MAX   = IDX_W'(MAX_VALUE);
   localparam logic [ADDR_W-1:0] SWEEP_END = ADDR_W'(MAX_VALUE - 1);

   // Sequencer and datapath registers
   pc_type               pc_ff,        pc_in;
   logic                 boot_ff,      boot_in;
   logic [EPOCH_W-1:0]   epoch_ff,     epoch_in;
   logic [ADDR_W-1:0]    sweep_ff,     sweep_in;
   logic [VALUE_W-1:0]   value_ff,     value_in;
   logic                 first_ff,     first_in;
   logic                 rej_ff,       rej_in;
   logic [IDX_W-1:0]     idx_ff,       idx_in;
   logic [LEN_W-1:0]     acc_ff,       acc_in;
   logic [LEN_W-1:0]     len_ff,       len_in;
   logic [LEN_W-1:0]     best_ff,      best_in;
   logic                 pend_ff,      pend_in;
   logic [ADDR_W-1:0]    pend_addr_ff, pend_addr_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [LEN_W-1:0]     rsp_end_ff,   rsp_end_in;
   logic [LEN_W-1:0]     rsp_best_ff,  rsp_best_in;
   logic                 rsp_rej_ff,   rsp_rej_in;

   // RAM port
   logic                 ram_wr_en;
   logic [ADDR_W-1:0]    ram_wr_addr;
   logic [DATA_W-1:0]    ram_wr_data;
   logic                 ram_rd_en;
   logic [ADDR_W-1:0]    ram_rd_addr;
   logic [DATA_W-1:0]    ram_rd_data;

   ucode_type            uc;
   logic                 req_take;
   logic                 out_free;
   logic                 value_bad;
   logic                 idx_nz;
   logic                 idx_in_tree;
   logic [IDX_W-1:0]     low_bit;
   logic [LEN_W-1:0]     rd_len;
   logic [LEN_W-1:0]     len_next;
   logic                 emit_load;

   lisfw_ram #(
      .WIDTH (DATA_W),
      .DEPTH (MAX_VALUE)
   ) u_tree (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign uc         = ucode_rom(pc_ff);
   assign req_tready = (uc.op == OP_FETCH);
   assign req_take   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign value_bad   = (value_ff == '0) || (32'(value_ff) > 32'(MAX_VALUE));
   assign idx_nz      = (idx_ff != '0);
   assign idx_in_tree = idx_nz && (idx_ff <= IDX_MAX);
   assign low_bit     = idx_ff & (~idx_ff + IDX_W'(1));

   // An entry tagged with an older sequence reads as empty
   assign rd_len   = (ram_rd_data[DATA_W-1:LEN_W] == epoch_ff) ? ram_rd_data[LEN_W-1:0] : '0;
   assign len_next = (acc_ff == LEN_MAX) ? LEN_MAX : acc_ff + LEN_W'(1);

   assign emit_load = (uc.op == OP_EMIT) && out_free;

   always_comb begin
      pc_in        = pc_ff;
      boot_in      = boot_ff;
      epoch_in     = epoch_ff;
      sweep_in     = sweep_ff;
      value_in     = value_ff;
      first_in     = first_ff;
      rej_in       = rej_ff;
      idx_in       = idx_ff;
      acc_in       = acc_ff;
      len_in       = len_ff;
      best_in      = best_ff;
      pend_in      = pend_ff;
      pend_addr_in = pend_addr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_end_in   = rsp_end_ff;
      rsp_best_in  = rsp_best_ff;
      rsp_rej_in   = rsp_rej_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = pend_addr_ff;
      ram_wr_data  = {epoch_ff, (rd_len > len_ff) ? rd_len : len_ff};
      ram_rd_en    = 1'b0;
      ram_rd_addr  = ADDR_W'(idx_ff - IDX_W'(1));

      // Datapath
      unique case (uc.op)
         OP_FETCH: begin
            if (req_take) begin
               value_in = req_tdata[VALUE_W-1:0];
               first_in = req_tuser;
            end
         end
         OP_NEWSEQ: begin
            if (first_ff) begin
               best_in  = '0;
               epoch_in = epoch_ff + EPOCH_W'(1);
            end
         end
         OP_QINIT: begin
            rej_in  = value_bad;
            idx_in  = IDX_W'(value_ff) - IDX_W'(1);
            acc_in  = '0;
            len_in  = '0;
            pend_in = 1'b0;
         end
         OP_QSTEP: begin
            // fold in last cycle's read, launch the next one
            if (pend_ff && (rd_len > acc_ff)) begin
               acc_in = rd_len;
            end
            pend_in = idx_nz;
            if (idx_nz) begin
               ram_rd_en = 1'b1;
               idx_in    = idx_ff - low_bit;
            end
         end
         OP_UINIT: begin
            len_in  = len_next;
            idx_in  = IDX_W'(value_ff);
            pend_in = 1'b0;
            if (len_next > best_ff) begin
               best_in = len_next;
            end
         end
         OP_USTEP: begin
            // write back the entry read last cycle, read the next one up
            ram_wr_en = pend_ff;
            pend_in   = idx_in_tree;
            if (idx_in_tree) begin
               ram_rd_en    = 1'b1;
               pend_addr_in = ADDR_W'(idx_ff - IDX_W'(1));
               idx_in       = idx_ff + low_bit;
            end
         end
         OP_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_end_in   = rej_ff ? '0 : len_ff;
               rsp_best_in  = best_ff;
               rsp_rej_in   = rej_ff;
            end
         end
         OP_SWEEP: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = sweep_ff;
            ram_wr_data = '0;
            sweep_in    = (sweep_ff == SWEEP_END) ? '0 : sweep_ff + ADDR_W'(1);
            if (sweep_ff == SWEEP_END) begin
               boot_in = 1'b0;
            end
         end
         default: ;
      endcase

      // Sequencing
      unique case (uc.jump)
         J_WAIT_IN:    pc_in = (uc.op == OP_FETCH && !req_take) ? pc_ff : pc_ff + PC_W'(1);
         J_WRAP:       pc_in = (first_ff && epoch_ff == '1) ? uc.target : pc_ff + PC_W'(1);
         J_REJ:        pc_in = value_bad ? uc.target : pc_ff + PC_W'(1);
         J_LOOP_NZ:    pc_in = idx_nz ? uc.target : pc_ff + PC_W'(1);
         J_LOOP_RANGE: pc_in = idx_in_tree ? uc.target : pc_ff + PC_W'(1);
         J_WAIT_OUT:   pc_in = out_free ? uc.target : pc_ff;
         J_SWEEP: begin
            if (sweep_ff != SWEEP_END) begin
               pc_in = pc_ff;
            end else begin
               pc_in = boot_ff ? P_FETCH : uc.target;
            end
         end
         default:      pc_in = P_FETCH;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= P_SWEEP;
         boot_ff      <= 1'b1;
         epoch_ff     <= '0;
         sweep_ff     <= '0;
         best_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         boot_ff      <= boot_in;
         epoch_ff     <= epoch_in;
         sweep_ff     <= sweep_in;
         best_ff      <= best_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      value_ff     <= value_in;
      first_ff     <= first_in;
      rej_ff       <= rej_in;
      idx_ff       <= idx_in;
      acc_ff       <= acc_in;
      len_ff       <= len_in;
      pend_addr_ff <= pend_addr_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_best_ff  <= rsp_best_in;
      rsp_rej_ff   <= rsp_rej_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_best_ff, rsp_end_ff};
   assign rsp_tuser  = rsp_rej_ff;

   // No input is taken before the tree RAM has been swept
   a_boot_blocks_req: assert property (@(posedge clock) disable iff (reset)
      boot_ff |-> !req_tready)
      else $error("request taken during boot sweep");

   // The query walk only reads the tree
   a_query_no_write: assert property (@(posedge clock) disable iff (reset)
      (uc.op == OP_QSTEP) |-> !ram_wr_en)
      else $error("tree write during query walk");

   // A new result never overwrites one that has not been taken
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit_load |-> (!rsp_valid_ff || rsp_tready))
      else $error("result register overwritten");

   // A rejected item reports zero length; an accepted one never beats the best
   a_rej_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_rej_ff) |-> (rsp_end_ff == '0))
      else $error("rejected item with nonzero length");

   a_best_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_best_ff >= rsp_end_ff))
      else $error("ending length above best length");

endmodule

// File: sv/lisfw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
module lisfw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
